// ===== rtl/core/range_max_known_tree_defines.svh =====
// Assertion macros used by the range max tree controller RTL
`ifndef RANGE_MAX_KNOWN_TREE_DEFINES_SVH
`define RANGE_MAX_KNOWN_TREE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define RMKT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define RMKT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rmkt_pkg.sv =====
// Package: widths, defaults and controller/datapath interface types
`timescale 1ns / 1ps
package rmkt_pkg;

  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned NODE_W     = VALUE_W + 1;
  localparam int unsigned LEAVES_DEF = 1024;

  typedef struct packed {
    logic clr;
    logic load;
    logic upd_leaf;
    logic upd_rd;
    logic upd_wr;
    logic q_lo;
    logic q_hi;
  } rmkt_cmd_t;

  typedef struct packed {
    logic is_query;
    logic wr_ok;
    logic clr_last;
    logic upd_root;
    logic lo_lt_hi;
  } rmkt_status_t;

endpackage

// ===== rtl/core/rmkt_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module rmkt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/rmkt_dp.sv =====
// Datapath: node memory, walk pointers, accumulator and result registers
`timescale 1ns / 1ps
module rmkt_dp #(
  parameter int unsigned LEAVES = rmkt_pkg::LEAVES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmkt_pkg::rmkt_cmd_t           cmd,
  output rmkt_pkg::rmkt_status_t        st,
  input  logic                          in_op,
  input  logic [rmkt_pkg::INDEX_W-1:0]  in_first_index,
  input  logic [rmkt_pkg::INDEX_W-1:0]  in_last_index,
  input  logic [rmkt_pkg::VALUE_W-1:0]  in_value,
  output logic [rmkt_pkg::VALUE_W-1:0]  out_range_max,
  output logic                          out_all_known
);
  import rmkt_pkg::*;

  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  logic [AW-1:0]      clr_r;
  logic [AW-1:0]      node_r;
  logic [NODE_W-1:0]  cur_r;
  logic [CW-1:0]      lo_r;
  logic [CW-1:0]      hi_r;
  logic [VALUE_W-1:0] acc_max_r;
  logic               acc_known_r;
  logic               pend_r;
  logic [VALUE_W-1:0] out_max_r;
  logic               out_known_r;

  logic [CW-1:0]      first_ext;
  logic [CW-1:0]      last_ext;
  logic               first_ok;
  logic               last_ok;
  logic               q_ok;
  logic [CW-1:0]      lo_ld;
  logic [CW-1:0]      hi_ld;
  logic [CW-1:0]      hi_dec;
  logic               lo_odd;
  logic               hi_odd;
  logic [VALUE_W-1:0] rd_max;
  logic               rd_known;
  logic [NODE_W-1:0]  merged;
  logic [VALUE_W-1:0] acc_max_nxt;
  logic               acc_known_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [NODE_W-1:0]  mem_wdata;
  logic [NODE_W-1:0]  mem_rdata;

  rmkt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign first_ext = CW'(in_first_index);
  assign last_ext  = CW'(in_last_index);
  assign first_ok  = (first_ext != '0) && (first_ext <= LEAVES_C);
  assign last_ok   = (last_ext != '0) && (last_ext <= LEAVES_C);
  assign q_ok      = first_ok && last_ok && (first_ext <= last_ext);
  assign lo_ld     = LEAVES_C + first_ext - CW'(1);
  assign hi_ld     = LEAVES_C + last_ext;

  assign lo_odd = lo_r[0];
  assign hi_odd = hi_r[0];
  assign hi_dec = hi_r - CW'(hi_odd);

  assign rd_max   = mem_rdata[VALUE_W-1:0];
  assign rd_known = mem_rdata[NODE_W-1];

  assign merged = {cur_r[NODE_W-1] & rd_known,
                   (rd_max > cur_r[VALUE_W-1:0]) ? rd_max : cur_r[VALUE_W-1:0]};

  assign acc_max_nxt   = (pend_r && (rd_max > acc_max_r)) ? rd_max : acc_max_r;
  assign acc_known_nxt = acc_known_r & (~pend_r | rd_known);

  assign st.is_query = in_op;
  assign st.wr_ok    = first_ok;
  assign st.clr_last = (clr_r == CLR_LAST);
  assign st.upd_root = (node_r[AW-1:1] == (AW-1)'(1));
  assign st.lo_lt_hi = (lo_r < hi_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = node_r;
    mem_wdata = cur_r;
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_addr  = clr_r;
      mem_wdata = '0;
    end else if (cmd.upd_leaf) begin
      mem_we    = 1'b1;
    end else if (cmd.upd_rd) begin
      mem_addr  = node_r ^ AW'(1);
    end else if (cmd.upd_wr) begin
      mem_we    = 1'b1;
      mem_addr  = node_r >> 1;
      mem_wdata = merged;
    end else if (cmd.q_lo) begin
      mem_addr  = lo_r[AW-1:0];
    end else if (cmd.q_hi) begin
      mem_addr  = hi_dec[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r      <= lo_ld[AW-1:0];
      cur_r       <= {1'b1, in_value};
      acc_max_r   <= '0;
      acc_known_r <= 1'b1;
      pend_r      <= 1'b0;
      lo_r        <= q_ok ? lo_ld : '0;
      hi_r        <= q_ok ? hi_ld : '0;
    end
    if (cmd.upd_wr) begin
      cur_r  <= merged;
      node_r <= node_r >> 1;
    end
    if (cmd.q_lo) begin
      acc_max_r   <= acc_max_nxt;
      acc_known_r <= acc_known_nxt;
      if (st.lo_lt_hi) begin
        pend_r <= lo_odd;
        lo_r   <= lo_r + CW'(lo_odd);
      end else begin
        pend_r      <= 1'b0;
        out_max_r   <= acc_max_nxt;
        out_known_r <= acc_known_nxt;
      end
    end
    if (cmd.q_hi) begin
      acc_max_r   <= acc_max_nxt;
      acc_known_r <= acc_known_nxt;
      pend_r      <= hi_odd;
      lo_r        <= lo_r >> 1;
      hi_r        <= hi_dec >> 1;
    end
  end

  assign out_range_max = out_max_r;
  assign out_all_known = out_known_r;

endmodule

// ===== rtl/core/rmkt_ctrl.sv =====
// Controller: clear pass, update walk and query walk sequencing
`timescale 1ns / 1ps
`include "range_max_known_tree_defines.svh"
module rmkt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output logic                   out_valid,
  output rmkt_pkg::rmkt_cmd_t    cmd,
  input  rmkt_pkg::rmkt_status_t st
);
  import rmkt_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UWL  = 3'd2;
  localparam logic [2:0] S_URD  = 3'd3;
  localparam logic [2:0] S_UWR  = 3'd4;
  localparam logic [2:0] S_QLO  = 3'd5;
  localparam logic [2:0] S_QHI  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.is_query) begin
            state_nxt = S_QLO;
          end else if (st.wr_ok) begin
            state_nxt = S_UWL;
          end
        end
      end
      S_UWL: begin
        cmd.upd_leaf = 1'b1;
        state_nxt    = S_URD;
      end
      S_URD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = S_UWR;
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = st.upd_root ? S_IDLE : S_URD;
      end
      S_QLO: begin
        cmd.q_lo = 1'b1;
        if (st.lo_lt_hi) begin
          state_nxt = S_QHI;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_QHI: begin
        cmd.q_hi  = 1'b1;
        state_nxt = S_QLO;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `RMKT_ASSERT_IMP(a_out_from_query, clk, rst_n, out_valid_r, $past(state_r == S_QLO), "result without query end")
  `RMKT_ASSERT_NXT(a_out_single, clk, rst_n, out_valid_r, !out_valid_r, "result strobe held")
  `RMKT_ASSERT_NXT(a_upd_climb, clk, rst_n, (state_r == S_UWR) && !st.upd_root, state_r == S_URD, "update walk stopped early")

endmodule

// ===== rtl/core/range_max_known_tree.sv =====
// Top level: range max / all-known tree with point update
// Update: writes the leaf, then one sibling read and one write per level up to the root.
// Query: alternates low-end and high-end steps, one pair per tree level walked.
// Both walks go through one single-port node memory; one item at a time, busy while working.
// Reset starts a clearing pass over every node entry with busy held high.
// A result is strobed on out_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module range_max_known_tree #(
  parameter int unsigned LEAVES = rmkt_pkg::LEAVES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [rmkt_pkg::INDEX_W-1:0]  in_first_index,
  input  logic [rmkt_pkg::INDEX_W-1:0]  in_last_index,
  input  logic [rmkt_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [rmkt_pkg::VALUE_W-1:0]  out_range_max,
  output logic                          out_all_known
);
  import rmkt_pkg::*;

  rmkt_cmd_t    cmd;
  rmkt_status_t st;

  rmkt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .st        (st)
  );

  rmkt_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_op          (in_op),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_value       (in_value),
    .out_range_max  (out_range_max),
    .out_all_known  (out_all_known)
  );

endmodule
